/* design/jvs_pkg.sv */
// ============================================================================
// jvs_pkg: shared types and constants of the joystick velocity shaper
// Holds register indexes, controller commands, state codes and the fixed
// point constants used by the datapath.
// ============================================================================
`default_nettype none

package jvs_pkg;

    // number of velocity axes
    localparam int unsigned AXES = 3;

    // payload types
    typedef logic signed [15:0] t_vel;   // Q4.11 command
    typedef logic signed [16:0] t_axis;  // negated Q1.14 stick value, or offset trigger

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_BOOST_SCALE     = 3'd0,
        REG_BOOST_RATIO     = 3'd1,
        REG_SMOOTH_ENABLE   = 3'd2,
        REG_SLEW_STEP       = 3'd3,
        REG_STAND_THRESHOLD = 3'd4
    } t_reg;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_P1,
        OP_P2,
        OP_FACT,
        OP_MLO,
        OP_MHI,
        OP_ACC,
        OP_ROUND,
        OP_SLEW,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] axis;
    } t_cmd;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_P1,
        ST_P2,
        ST_FACT,
        ST_MLO,
        ST_MHI,
        ST_ACC,
        ST_ROUND,
        ST_SLEW,
        ST_OUT
    } t_state;

    // reset values of the configuration registers
    localparam logic [15:0] BOOST_SCALE_RST     = 16'd0;
    localparam logic [15:0] BOOST_RATIO_RST     = 16'd4096;
    localparam logic [14:0] SLEW_STEP_RST       = 15'd410;
    localparam logic [14:0] STAND_THRESHOLD_RST = 15'd205;

    // fixed point constants
    localparam logic signed [16:0] RATIO_ONE   = 17'sd4096;             // 1.0 in Q4.12
    localparam logic signed [16:0] TRIG_OFFSET = 17'sd16384;            // 1.0 in Q1.14
    localparam logic signed [49:0] FACTOR_ONE  = 50'sd549755813888;     // 1.0 in Q39
    localparam logic signed [64:0] ROUND_HALF  = 65'sd2199023255552;    // half lsb of Q11 in Q53
    localparam int unsigned        LO_BITS     = 24;                    // split of the factor
    localparam logic signed [22:0] VEL_MAX     = 23'sd32767;
    localparam logic signed [22:0] VEL_MIN     = -23'sd32768;

endpackage

`default_nettype wire

/* design/jvs_ctrl.sv */
// ============================================================================
// jvs_ctrl: sequencing controller
// Walks the factor build and per-axis multiply, round and slew steps, one
// datapath command per cycle unless the output stalls; owns both handshakes.
// ============================================================================
`default_nettype none

module jvs_ctrl
    import jvs_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_valid,
    output logic o_ready,
    output logic o_valid,
    input  wire  i_ready,
    output t_cmd o_cmd
);

    t_state     r_state, n_state;
    logic [1:0] r_axis, n_axis;
    logic       r_valid, n_valid;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_axis  <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
            r_valid <= n_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_axis     = r_axis;
        n_valid    = r_valid & ~i_ready;
        o_cmd.op   = OP_NONE;
        o_cmd.axis = r_axis;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = ST_P1;
                    n_axis   = 2'd0;
                end
            end
            ST_P1: begin
                o_cmd.op = OP_P1;
                n_state  = ST_P2;
            end
            ST_P2: begin
                o_cmd.op = OP_P2;
                n_state  = ST_FACT;
            end
            ST_FACT: begin
                o_cmd.op = OP_FACT;
                n_state  = ST_MLO;
            end
            ST_MLO: begin
                o_cmd.op = OP_MLO;
                n_state  = ST_MHI;
            end
            ST_MHI: begin
                o_cmd.op = OP_MHI;
                n_state  = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.op = OP_ACC;
                n_state  = ST_ROUND;
            end
            ST_ROUND: begin
                o_cmd.op = OP_ROUND;
                n_state  = ST_SLEW;
            end
            ST_SLEW: begin
                o_cmd.op = OP_SLEW;
                if (r_axis == 2'(AXES - 1)) begin
                    n_state = ST_OUT;
                end else begin
                    n_axis  = r_axis + 2'd1;
                    n_state = ST_MLO;
                end
            end
            ST_OUT: begin
                // load the output register once it is free or being taken
                if (!r_valid || i_ready) begin
                    o_cmd.op = OP_OUT;
                    n_valid  = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = r_valid;

endmodule

`default_nettype wire

/* design/jvs_datapath.sv */
// ============================================================================
// jvs_datapath: arithmetic of the velocity shaper
// Configuration registers, one shared signed multiplier, accumulate, round
// and saturate to Q4.11, slew limiting of the held command, stand detect.
// ============================================================================
`default_nettype none

module jvs_datapath
    import jvs_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire  t_cmd  i_cmd,
    input  wire  [15:0] i_left_stick_x,
    input  wire  [15:0] i_left_stick_y,
    input  wire  [15:0] i_right_stick_x,
    input  wire  [15:0] i_trigger_level,
    input  wire         i_cfg_valid,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [15:0] i_cfg_data,
    output logic [15:0] o_vel_forward,
    output logic [15:0] o_vel_sideways,
    output logic [15:0] o_vel_yaw,
    output logic        o_stand
);

    // configuration
    logic [15:0] r_scale;
    logic [15:0] r_ratio;
    logic        r_smooth;
    logic [14:0] r_slew;
    logic [14:0] r_thr;

    // working registers
    t_axis              r_axis [AXES];
    t_axis              r_trig;
    logic signed [49:0] r_prod;
    logic signed [42:0] r_plo;
    logic signed [49:0] r_factor;
    logic signed [64:0] r_acc;
    t_vel               r_target;
    t_vel               r_held [AXES];
    logic               r_standing;
    t_vel               r_out [AXES];
    logic               r_out_stand;

    // combinational signals
    t_axis              axis_sel;
    t_axis              ratio_m;
    logic signed [33:0] mul_a;
    logic signed [25:0] mul_b;
    logic signed [59:0] mul_p;
    logic signed [64:0] acc_rnd;
    logic signed [22:0] q;
    t_vel               sat;
    t_vel               held_sel;
    logic signed [16:0] diff;
    logic signed [16:0] lim;
    logic signed [16:0] step;
    logic signed [16:0] held_sum;
    t_vel               held_new;
    logic signed [16:0] mag;

    // configuration writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale  <= BOOST_SCALE_RST;
            r_ratio  <= BOOST_RATIO_RST;
            r_smooth <= 1'b0;
            r_slew   <= SLEW_STEP_RST;
            r_thr    <= STAND_THRESHOLD_RST;
        end else if (i_cfg_valid) begin
            unique case (t_reg'(i_cfg_index))
                REG_BOOST_SCALE:     r_scale  <= i_cfg_data;
                REG_BOOST_RATIO:     r_ratio  <= i_cfg_data;
                REG_SMOOTH_ENABLE:   r_smooth <= i_cfg_data[0];
                REG_SLEW_STEP:       r_slew   <= i_cfg_data[14:0];
                REG_STAND_THRESHOLD: r_thr    <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    assign axis_sel = r_axis[i_cmd.axis];
    assign ratio_m  = $signed({1'b0, r_ratio}) - RATIO_ONE;

    // shared multiplier operand selection
    always_comb begin
        case (i_cmd.op)
            OP_P1: begin
                mul_a = $signed({18'd0, r_scale});
                mul_b = 26'(ratio_m);
            end
            OP_P2: begin
                mul_a = $signed(r_prod[33:0]);
                mul_b = 26'(r_trig);
            end
            OP_MLO: begin
                mul_a = 34'(axis_sel);
                mul_b = $signed({2'b00, r_factor[LO_BITS-1:0]});
            end
            OP_MHI: begin
                mul_a = 34'(axis_sel);
                mul_b = $signed(r_factor[49:LO_BITS]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // round half away from zero and saturate to Q4.11
    assign acc_rnd = r_acc + ROUND_HALF - $signed({64'd0, r_acc[64]});
    assign q       = acc_rnd[64:42];
    always_comb begin
        if (q > VEL_MAX) begin
            sat = t_vel'(VEL_MAX);
        end else if (q < VEL_MIN) begin
            sat = t_vel'(VEL_MIN);
        end else begin
            sat = q[15:0];
        end
    end

    // slew limiting and magnitude of the new held value
    assign held_sel = r_held[i_cmd.axis];
    assign diff     = 17'(r_target) - 17'(held_sel);
    assign lim      = $signed({2'b00, r_slew});
    always_comb begin
        if (diff > lim) begin
            step = lim;
        end else if (diff < -lim) begin
            step = -lim;
        end else begin
            step = diff;
        end
    end
    assign held_sum = 17'(held_sel) + step;
    assign held_new = r_smooth ? held_sum[15:0] : r_target;
    assign mag      = held_new[15] ? -17'(held_new) : 17'(held_new);

    // working registers without reset
    always_ff @(posedge i_clk) begin
        case (i_cmd.op) inside
            OP_LOAD: begin
                r_axis[0] <= -17'($signed(i_left_stick_y));
                r_axis[1] <= -17'($signed(i_left_stick_x));
                r_axis[2] <= -17'($signed(i_right_stick_x));
                r_trig    <= 17'($signed(i_trigger_level)) + TRIG_OFFSET;
            end
            OP_P1, OP_P2, OP_MLO: begin
                r_prod <= mul_p[49:0];
            end
            OP_MHI: begin
                r_prod <= mul_p[49:0];
                r_plo  <= r_prod[42:0];
            end
            OP_FACT: begin
                r_factor <= r_prod + FACTOR_ONE;
            end
            OP_ACC: begin
                r_acc <= (65'(r_prod) <<< LO_BITS) + 65'(r_plo);
            end
            OP_ROUND: begin
                r_target <= sat;
            end
            default: ;
        endcase
    end

    // held command, stand flag and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < AXES; k++) begin
                r_held[k] <= '0;
            end
            r_standing <= 1'b1;
        end else begin
            case (i_cmd.op)
                OP_LOAD: begin
                    r_standing <= 1'b1;
                end
                OP_SLEW: begin
                    r_held[i_cmd.axis] <= held_new;
                    if (mag >= $signed({2'b00, r_thr})) begin
                        r_standing <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_OUT) begin
            for (int k = 0; k < AXES; k++) begin
                r_out[k] <= r_standing ? '0 : r_held[k];
            end
            r_out_stand <= r_standing;
        end
    end

    assign o_vel_forward  = r_out[0];
    assign o_vel_sideways = r_out[1];
    assign o_vel_yaw      = r_out[2];
    assign o_stand        = r_out_stand;

endmodule

`default_nettype wire

/* design/joystick_velocity_shaper_top.sv */
// ============================================================================
// joystick_velocity_shaper_top: gamepad sample to velocity command
// Boosts the negated stick axes by the trigger, saturates to Q4.11, slew
// limits the held command when smoothing is enabled and reports standing
// under a threshold.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+----------------------------------
//  input     | i_valid / o_ready          | i_left_stick_x, i_left_stick_y,
//            |                            | i_right_stick_x, i_trigger_level
//  output    | o_valid / i_ready          | o_vel_forward, o_vel_sideways,
//            |                            | o_vel_yaw, o_stand
//  config    | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// From acceptance to o_valid a sample passes these steps: build the boost
// factor, then take each axis in turn through the one shared multiplier
// (two partial products, accumulate, round, slew), then load the output.
// o_ready returns as the result appears, so a sample is taken while the
// previous result still waits. A stalled output holds the sequencer in
// its last step. Synchronous active-low reset; no clearing pass.
//
`default_nettype none

module joystick_velocity_shaper_top
    import jvs_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [15:0] i_left_stick_x,
    input  wire  [15:0] i_left_stick_y,
    input  wire  [15:0] i_right_stick_x,
    input  wire  [15:0] i_trigger_level,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [15:0] o_vel_forward,
    output logic [15:0] o_vel_sideways,
    output logic [15:0] o_vel_yaw,
    output logic        o_stand,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [15:0] i_cfg_data
);

    t_cmd cmd;

    // register writes are always taken
    assign o_cfg_ready = 1'b1;

    // sequencer
    jvs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd)
    );

    // arithmetic
    jvs_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_left_stick_x  (i_left_stick_x),
        .i_left_stick_y  (i_left_stick_y),
        .i_right_stick_x (i_right_stick_x),
        .i_trigger_level (i_trigger_level),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_vel_forward   (o_vel_forward),
        .o_vel_sideways  (o_vel_sideways),
        .o_vel_yaw       (o_vel_yaw),
        .o_stand         (o_stand)
    );

endmodule

`default_nettype wire

/* design/jvs_checker.sv */
// ============================================================================
// jvs_checker: port-level checks of the velocity shaper
// Watches the top level's ports for output stability, busy behaviour after
// an input transaction and zero commands while standing.
// ============================================================================
`default_nettype none

module jvs_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_valid,
    input wire        o_ready,
    input wire        o_valid,
    input wire        i_ready,
    input wire [15:0] o_vel_forward,
    input wire [15:0] o_vel_sideways,
    input wire [15:0] o_vel_yaw,
    input wire        o_stand
);

    // stalled result stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("output transaction dropped while stalled");

    // stalled result payload holds
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_vel_forward) && $stable(o_vel_sideways)
            && $stable(o_vel_yaw) && $stable(o_stand))
        else $error("output payload changed while stalled");

    // one sample at a time: busy after an input transaction
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready ##1 !o_ready)
        else $error("input taken while a sample is in progress");

    // standing forces a zero command
    a_stand_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_stand |-> o_vel_forward == 16'd0 && o_vel_sideways == 16'd0
            && o_vel_yaw == 16'd0)
        else $error("nonzero command while standing");

endmodule

bind joystick_velocity_shaper_top jvs_checker u_jvs_checker (.*);

`default_nettype wire
